@@ hdl/tag_header_validator_defines.svh @@
// Assertion macros for the tag header validator.
`ifndef TAG_HEADER_VALIDATOR_DEFINES_SVH
`define TAG_HEADER_VALIDATOR_DEFINES_SVH

// same-cycle implication
`define THV_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define THV_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ hdl/thv_pkg.sv @@
`default_nettype none
package thv_pkg;

	localparam int TYPE_BUFFER  = 20;
	localparam int NAME_LIMIT   = 40;
	localparam int BUFFER_BYTES = 4096;
	localparam int POS_W        = $clog2(BUFFER_BYTES + 1);
	localparam int MIN_SIZE     = 84;
	localparam int ZONE_MAX     = 1400;

	typedef enum logic [4:0] {
		PH_OBJ, PH_HEX, PH_TYPEKW, PH_TYPE, PH_TAGKW, PH_NAME1, PH_NAME,
		PH_TAGGERKW, PH_AUTH, PH_MAIL, PH_MAILGT, PH_STAMP1, PH_STAMP,
		PH_ZSIGN, PH_ZDIG, PH_ZNL, PH_BLANK, PH_BODY, PH_HALT
	} phase_t;

	typedef enum logic [4:0] {
		ERR_NONE, ERR_SHORT, ERR_OBJECT, ERR_HEX, ERR_TYPE, ERR_NEWLINE,
		ERR_TAG, ERR_TYPELEN, ERR_NAMECHAR, ERR_NAMELEN, ERR_TAGGER,
		ERR_TAGGER_FIELD, ERR_NAME, ERR_STAMP, ERR_STAMP_FORM, ERR_ZONE,
		ERR_GARBAGE
	} err_t;

	typedef struct packed {
		phase_t             phase;
		logic [POS_W-1:0]   bpos;
		logic [2:0]         fpos;
		err_t               first_error;
		logic [11:0]        fe_off;
		logic [7:0]         prev;
		logic [5:0]         tcount;
		logic [6:0]         ncount;
		logic [31:0]        stamp;
		logic [11:0]        zone;
		logic               tover;
		logic [11:0]        body;
		logic [POS_W-1:0]   fmark;
		logic [13:0]        zacc;
		logic               zneg;
	} thv_state_t;

	typedef struct packed {
		err_t         status;
		logic [11:0]  error_offset;
		logic [4:0]   type_length;
		logic [5:0]   tag_name_length;
		logic [31:0]  time_stamp;
		logic [11:0]  zone_offset;
		logic [11:0]  body_start;
	} thv_result_t;

	function automatic thv_state_t thv_reset_state();
		thv_state_t s;
		s = '0;
		s.phase = PH_OBJ;
		s.first_error = ERR_NONE;
		return s;
	endfunction

	function automatic logic [11:0] clamp12(logic [POS_W-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		return (w > 32'd4095) ? 12'd4095 : w[11:0];
	endfunction

	function automatic logic is_digit(logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_hex(logic [7:0] c);
		return is_digit(c) || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
	endfunction

	function automatic logic [7:0] kw_object(logic [2:0] i);
		logic [7:0] r;
		case (i)
			3'd0: r = 8'h6f;
			3'd1: r = 8'h62;
			3'd2: r = 8'h6a;
			3'd3: r = 8'h65;
			3'd4: r = 8'h63;
			3'd5: r = 8'h74;
			3'd6: r = 8'h20;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] kw_type(logic [2:0] i);
		logic [7:0] r;
		case (i)
			3'd0: r = 8'h0a;
			3'd1: r = 8'h74;
			3'd2: r = 8'h79;
			3'd3: r = 8'h70;
			3'd4: r = 8'h65;
			3'd5: r = 8'h20;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] kw_tag(logic [2:0] i);
		logic [7:0] r;
		case (i)
			3'd0: r = 8'h74;
			3'd1: r = 8'h61;
			3'd2: r = 8'h67;
			3'd3: r = 8'h20;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] kw_tagger(logic [2:0] i);
		logic [7:0] r;
		case (i)
			3'd0: r = 8'h74;
			3'd1: r = 8'h61;
			3'd2: r = 8'h67;
			3'd3: r = 8'h67;
			3'd4: r = 8'h65;
			3'd5: r = 8'h72;
			3'd6: r = 8'h20;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	// one byte of the header parser
	function automatic thv_state_t thv_step(thv_state_t s, logic [7:0] c,
			logic [POS_W-1:0] pos);
		thv_state_t       n;
		logic             err;
		err_t             ecode;
		logic [POS_W-1:0] eoff;
		logic             do_name;
		logic [35:0]      v;
		logic [2:0]       pidx;
		n = s;
		err = 1'b0;
		ecode = ERR_NONE;
		eoff = '0;
		do_name = 1'b0;
		v = '0;
		pidx = 3'(pos - POS_W'(47));
		case (s.phase)
			PH_OBJ: begin
				if (pos > POS_W'(6) || c != kw_object(pos[2:0])) begin
					err = 1'b1; ecode = ERR_OBJECT; eoff = '0;
				end else if (pos == POS_W'(6)) begin
					n.phase = PH_HEX;
				end
			end
			PH_HEX: begin
				if (!is_hex(c)) begin
					err = 1'b1; ecode = ERR_HEX; eoff = POS_W'(7);
				end else if (pos >= POS_W'(46)) begin
					n.phase = PH_TYPEKW;
				end
			end
			PH_TYPEKW: begin
				if (pos < POS_W'(47) || pos > POS_W'(52) || c != kw_type(pidx)) begin
					err = 1'b1; ecode = ERR_TYPE; eoff = POS_W'(47);
				end else if (pos == POS_W'(52)) begin
					n.phase = PH_TYPE;
					n.tcount = '0;
				end
			end
			PH_TYPE: begin
				if (c == 8'h0a) begin
					n.tover = 32'(s.tcount) >= 32'(TYPE_BUFFER);
					n.phase = PH_TAGKW;
					n.fpos = '0;
				end else if (c == 8'h00) begin
					err = 1'b1; ecode = ERR_NEWLINE; eoff = POS_W'(48);
				end else if (s.tcount != '1) begin
					n.tcount = s.tcount + 6'd1;
				end
			end
			PH_TAGKW: begin
				if (s.fpos > 3'd3 || c != kw_tag(s.fpos)) begin
					err = 1'b1; ecode = ERR_TAG; eoff = pos - POS_W'(s.fpos);
				end else begin
					n.fpos = s.fpos + 3'd1;
					if (s.fpos == 3'd3) n.phase = PH_NAME1;
				end
			end
			PH_NAME1: begin
				if (c == 8'h0a) begin
					err = 1'b1; ecode = ERR_TAG; eoff = pos - POS_W'(4);
				end else if (s.tover) begin
					err = 1'b1; ecode = ERR_TYPELEN; eoff = POS_W'(53);
				end else begin
					n.phase = PH_NAME;
					do_name = 1'b1;
				end
			end
			PH_NAME: do_name = 1'b1;
			PH_TAGGERKW: begin
				if (s.fpos > 3'd6 || c != kw_tagger(s.fpos)) begin
					err = 1'b1; ecode = ERR_TAGGER; eoff = pos - POS_W'(s.fpos);
				end else if (s.fpos == 3'd6) begin
					n.phase = PH_AUTH;
					n.fpos = '0;
					n.fmark = pos + POS_W'(1);
				end else begin
					n.fpos = s.fpos + 3'd1;
				end
			end
			PH_AUTH: begin
				if (c == 8'h3c) begin
					if (s.fpos != 3'd0 && s.prev == 8'h20) begin
						// fpos now flags an empty tagger name
						n.fpos = (s.fpos == 3'd1) ? 3'd1 : 3'd0;
						n.phase = PH_MAIL;
					end else begin
						err = 1'b1; ecode = ERR_TAGGER_FIELD; eoff = s.fmark;
					end
				end else if (c == 8'h3e || c == 8'h0a || c == 8'h00) begin
					err = 1'b1; ecode = ERR_TAGGER_FIELD; eoff = s.fmark;
				end else if (s.fpos != 3'd7) begin
					n.fpos = s.fpos + 3'd1;
				end
			end
			PH_MAIL: begin
				if (c == 8'h3e) begin
					n.phase = PH_MAILGT;
				end else if (c == 8'h3c || c == 8'h0a || c == 8'h20 || c == 8'h00) begin
					err = 1'b1; ecode = ERR_TAGGER_FIELD; eoff = s.fmark;
				end
			end
			PH_MAILGT: begin
				if (c != 8'h20) begin
					err = 1'b1; ecode = ERR_TAGGER_FIELD; eoff = s.fmark;
				end else if (s.fpos != 3'd0) begin
					err = 1'b1; ecode = ERR_NAME; eoff = s.fmark;
				end else begin
					n.phase = PH_STAMP1;
				end
			end
			PH_STAMP1: begin
				if (!is_digit(c)) begin
					err = 1'b1; ecode = ERR_STAMP; eoff = pos;
				end else begin
					n.stamp = 32'(c[3:0]);
					n.phase = PH_STAMP;
				end
			end
			PH_STAMP: begin
				if (is_digit(c)) begin
					v = {4'd0, s.stamp} * 36'd10 + 36'(c[3:0]);
					n.stamp = (v > 36'hFFFFFFFF) ? 32'hFFFFFFFF : v[31:0];
				end else if (c == 8'h20) begin
					n.phase = PH_ZSIGN;
					n.fmark = pos + POS_W'(1);
				end else begin
					err = 1'b1; ecode = ERR_STAMP_FORM; eoff = pos;
				end
			end
			PH_ZSIGN: begin
				if (c == 8'h2b || c == 8'h2d) begin
					n.zneg = (c == 8'h2d);
					n.zacc = '0;
					n.fpos = '0;
					n.phase = PH_ZDIG;
				end else begin
					err = 1'b1; ecode = ERR_ZONE; eoff = s.fmark;
				end
			end
			PH_ZDIG: begin
				if (!is_digit(c)) begin
					err = 1'b1; ecode = ERR_ZONE; eoff = s.fmark;
				end else begin
					n.zacc = 14'(s.zacc * 14'd10 + 14'(c[3:0]));
					n.fpos = s.fpos + 3'd1;
					if (s.fpos == 3'd3) n.phase = PH_ZNL;
				end
			end
			PH_ZNL: begin
				if (c != 8'h0a || 32'(s.zacc) > 32'(ZONE_MAX)) begin
					err = 1'b1; ecode = ERR_ZONE; eoff = s.fmark;
				end else begin
					n.zone = s.zneg ? 12'(-s.zacc[11:0]) : s.zacc[11:0];
					n.phase = PH_BLANK;
				end
			end
			PH_BLANK: begin
				if (c == 8'h0a) begin
					n.body = clamp12(pos + POS_W'(1));
					n.phase = PH_BODY;
				end else begin
					err = 1'b1; ecode = ERR_GARBAGE; eoff = pos;
				end
			end
			default: ;
		endcase
		if (do_name) begin
			if (c == 8'h0a) begin
				if (32'(s.ncount) >= 32'(NAME_LIMIT)) begin
					err = 1'b1; ecode = ERR_NAMELEN; eoff = pos;
				end else begin
					n.phase = PH_TAGGERKW;
					n.fpos = '0;
				end
			end else if (c <= 8'h20) begin
				err = 1'b1; ecode = ERR_NAMECHAR; eoff = pos + POS_W'(1);
			end else if (s.ncount != '1) begin
				n.ncount = s.ncount + 7'd1;
			end
		end
		if (err) begin
			if (s.first_error == ERR_NONE) begin
				n.first_error = ecode;
				n.fe_off = clamp12(eoff);
			end
			n.phase = PH_HALT;
		end
		n.prev = c;
		return n;
	endfunction

endpackage
`default_nettype wire

@@ hdl/thv_in_if.sv @@
`default_nettype none
interface thv_in_if;
	import thv_pkg::*;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_file;
	modport source (output valid, data_byte, end_of_file, input ready);
	modport sink (input valid, data_byte, end_of_file, output ready);
endinterface
`default_nettype wire

@@ hdl/thv_out_if.sv @@
`default_nettype none
interface thv_out_if;
	logic               valid;
	logic               ready;
	logic [4:0]         status;
	logic [11:0]        error_offset;
	logic [4:0]         type_length;
	logic [5:0]         tag_name_length;
	logic [31:0]        time_stamp;
	logic signed [11:0] zone_offset;
	logic [11:0]        body_start;
	modport source (output valid, status, error_offset, type_length, tag_name_length,
		time_stamp, zone_offset, body_start, input ready);
	modport sink (input valid, status, error_offset, type_length, tag_name_length,
		time_stamp, zone_offset, body_start, output ready);
endinterface
`default_nettype wire

@@ hdl/thv_core.sv @@
`default_nettype none
module thv_core
	import thv_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        step,
	input  wire logic [7:0]  data_byte,
	input  wire logic        end_of_file,
	output thv_result_t      result
);

	thv_state_t st_q, n1, n2;
	err_t status;
	logic [POS_W-1:0] size;

	always_comb begin
		n1 = st_q;
		if (32'(st_q.bpos) < 32'(BUFFER_BYTES)) begin
			n1 = thv_step(st_q, data_byte, st_q.bpos);
			n1.bpos = st_q.bpos + POS_W'(1);
		end
		size = n1.bpos;
		// end of buffer parses as a zero byte
		n2 = thv_step(n1, 8'h00, size);
		status = (32'(size) < 32'(MIN_SIZE)) ? ERR_SHORT : n2.first_error;
		result.status = status;
		result.error_offset = (status >= ERR_OBJECT) ? n2.fe_off : 12'd0;
		result.type_length = (n2.tcount > 6'd31) ? 5'd31 : n2.tcount[4:0];
		result.tag_name_length = (n2.ncount > 7'd63) ? 6'd63 : n2.ncount[5:0];
		result.time_stamp = n2.stamp;
		result.zone_offset = n2.zone;
		result.body_start = (status == ERR_NONE) ? n2.body : 12'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= thv_reset_state();
		end else if (step) begin
			st_q <= end_of_file ? thv_reset_state() : n1;
		end
	end

endmodule
`default_nettype wire

@@ hdl/tag_header_validator.sv @@
// Tag header validator: takes a tag file one byte per item and checks its
// header (object line with 40 hex digits, type line, tag line, tagger line,
// blank line). One item can be accepted every cycle. An item waits in an
// input register, then updates the parser state; the item flagged
// end_of_file also loads one result into the output register, which shows
// status, first error offset, field lengths, timestamp, zone and body start.
// Only the last byte of a file can wait: it stays in the input register, and
// stalls the input, while an earlier result is still not taken.
// The parser returns to its reset state after each file, so files may follow
// back to back. Bytes past the buffer size are dropped.
`default_nettype none
`include "tag_header_validator_defines.svh"
module tag_header_validator
	import thv_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	thv_in_if.sink   in_ch,
	thv_out_if.source out_ch
);

	// input register
	logic       s1_valid_q;
	logic [7:0] s1_byte_s1;
	logic       s1_eof_s1;

	// result register
	logic        res_valid_q;
	thv_result_t res_q;
	thv_result_t core_res;

	logic out_free, s1_move;

	// a result slot is free when empty or being taken now
	assign out_free = !res_valid_q || out_ch.ready;
	// plain bytes never wait; the last byte waits for a free result slot
	assign s1_move = s1_valid_q && (!s1_eof_s1 || out_free);
	assign in_ch.ready = !s1_valid_q || s1_move;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_ch.ready) begin
			s1_valid_q <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			s1_byte_s1 <= in_ch.data_byte;
			s1_eof_s1 <= in_ch.end_of_file;
		end
	end

	thv_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (s1_move),
		.data_byte   (s1_byte_s1),
		.end_of_file (s1_eof_s1),
		.result      (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s1_move && s1_eof_s1) begin
			res_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move && s1_eof_s1) begin
			res_q <= core_res;
		end
	end

	assign out_ch.valid = res_valid_q;
	assign out_ch.status = res_q.status;
	assign out_ch.error_offset = res_q.error_offset;
	assign out_ch.type_length = res_q.type_length;
	assign out_ch.tag_name_length = res_q.tag_name_length;
	assign out_ch.time_stamp = res_q.time_stamp;
	assign out_ch.zone_offset = res_q.zone_offset;
	assign out_ch.body_start = res_q.body_start;

	`THV_ASSERT_NEXT(a_last_gives_result, s1_move && s1_eof_s1, res_valid_q)
	`THV_ASSERT_NOW(a_short_no_offset, res_valid_q && res_q.status == ERR_SHORT,
		res_q.error_offset == 12'd0)
	`THV_ASSERT_NOW(a_err_no_body, res_valid_q && res_q.status != ERR_NONE,
		res_q.body_start == 12'd0)

endmodule
`default_nettype wire

@@ tb/tag_header_validator_tb.sv @@
`default_nettype none
module tag_header_validator_tb;
	import thv_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;
	localparam int TARGET_ITEMS = 1950;
	localparam int MIN_FILES = 2;
	localparam int HOLD_START = 600;   // accepted bytes before the long output hold
	localparam int HOLD_CYCLES = 300;

	typedef struct {
		logic [7:0] data;
		logic       last;
		bit         drain;   // wait for all results before offering this byte
	} byte_item_t;

	typedef struct {
		err_t        status;
		logic [11:0] err_off;
		logic [4:0]  type_len;
		logic [5:0]  name_len;
		logic [31:0] stamp;
		logic [11:0] zone;
		logic [11:0] body;
	} verdict_t;

	logic clk;
	logic arst_n;

	thv_in_if  in_ch();
	thv_out_if out_ch();

	tag_header_validator DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.in_ch (in_ch),
		.out_ch(out_ch)
	);

	byte_item_t byte_feed[$];     // bytes waiting to be offered
	verdict_t   verdicts_due[$];  // predicted results, oldest first
	logic [7:0] file_buf[$];      // file under construction
	int         fails;
	int         cycles;
	int         bytes_taken;
	int         hold_left;
	bit         hold_done;

	// offsets of the header lines inside the file being built
	int mark_tag, mark_tagger, mark_stamp, mark_zone, mark_blank;

	// ---------------------------------------------------------------
	// Header parser model: one call per byte, same rules as the block.
	// ---------------------------------------------------------------
	phase_t      hp_phase;
	err_t        hp_err;
	int unsigned hp_pos, hp_fpos, hp_err_off, hp_tcnt, hp_ncnt, hp_stamp;
	int unsigned hp_zacc, hp_body, hp_fmark;
	int          hp_zone;
	logic [7:0]  hp_prev;
	bit          hp_tover, hp_zneg;

	function automatic bit is_dec(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit is_hexdig(logic [7:0] c);
		return is_dec(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
	endfunction

	function automatic int unsigned sat_inc(int unsigned v);
		return (v < 65535) ? v + 1 : v;
	endfunction

	function automatic logic [11:0] cap12(int unsigned v);
		return (v > 4095) ? 12'd4095 : v[11:0];
	endfunction

	task automatic parser_clear();
		hp_phase = PH_OBJ;
		hp_err = ERR_NONE;
		hp_pos = 0; hp_fpos = 0; hp_err_off = 0; hp_tcnt = 0; hp_ncnt = 0;
		hp_stamp = 0; hp_zacc = 0; hp_body = 0; hp_fmark = 0; hp_zone = 0;
		hp_prev = 0; hp_tover = 0; hp_zneg = 0;
	endtask

	task automatic hdr_error(err_t e, int unsigned off);
		if (hp_err == ERR_NONE) begin
			hp_err = e;
			hp_err_off = off;
		end
		hp_phase = PH_HALT;
	endtask

	task automatic parse_byte(logic [7:0] c, int unsigned pos);
		string kw_obj, kw_typ, kw_tag, kw_tgr;
		bit    name_char;
		longint unsigned acc;
		kw_obj = "object ";
		kw_typ = "\ntype ";
		kw_tag = "tag ";
		kw_tgr = "tagger ";
		name_char = 0;
		case (hp_phase)
			PH_OBJ: begin
				if (pos > 6 || c != kw_obj[pos]) hdr_error(ERR_OBJECT, 0);
				else if (pos == 6) hp_phase = PH_HEX;
			end
			PH_HEX: begin
				if (!is_hexdig(c)) hdr_error(ERR_HEX, 7);
				else if (pos >= 46) hp_phase = PH_TYPEKW;
			end
			PH_TYPEKW: begin
				if (pos < 47 || pos > 52 || c != kw_typ[pos - 47]) hdr_error(ERR_TYPE, 47);
				else if (pos == 52) begin
					hp_phase = PH_TYPE;
					hp_tcnt = 0;
				end
			end
			PH_TYPE: begin
				if (c == 8'h0a) begin
					hp_tover = hp_tcnt >= TYPE_BUFFER;
					hp_phase = PH_TAGKW;
					hp_fpos = 0;
				end else if (c == 8'h00) hdr_error(ERR_NEWLINE, 48);
				else hp_tcnt = sat_inc(hp_tcnt);
			end
			PH_TAGKW: begin
				if (hp_fpos > 3 || c != kw_tag[hp_fpos]) hdr_error(ERR_TAG, pos - hp_fpos);
				else begin
					hp_fpos++;
					if (hp_fpos == 4) hp_phase = PH_NAME1;
				end
			end
			PH_NAME1: begin
				// first name byte: empty name, then the pending type length check
				if (c == 8'h0a) hdr_error(ERR_TAG, pos - 4);
				else if (hp_tover) hdr_error(ERR_TYPELEN, 53);
				else begin
					hp_phase = PH_NAME;
					name_char = 1;
				end
			end
			PH_NAME: name_char = 1;
			PH_TAGGERKW: begin
				if (hp_fpos > 6 || c != kw_tgr[hp_fpos]) hdr_error(ERR_TAGGER, pos - hp_fpos);
				else begin
					hp_fpos++;
					if (hp_fpos == 7) begin
						hp_phase = PH_AUTH;
						hp_fpos = 0;
						hp_fmark = pos + 1;
					end
				end
			end
			PH_AUTH: begin
				if (c == "<") begin
					if (hp_fpos > 0 && hp_prev == " ") begin
						// hp_fpos becomes the empty-name flag
						hp_fpos = (hp_fpos == 1) ? 1 : 0;
						hp_phase = PH_MAIL;
					end else hdr_error(ERR_TAGGER_FIELD, hp_fmark);
				end else if (c == ">" || c == 8'h0a || c == 8'h00) begin
					hdr_error(ERR_TAGGER_FIELD, hp_fmark);
				end else hp_fpos = sat_inc(hp_fpos);
			end
			PH_MAIL: begin
				if (c == ">") hp_phase = PH_MAILGT;
				else if (c == "<" || c == 8'h0a || c == " " || c == 8'h00)
					hdr_error(ERR_TAGGER_FIELD, hp_fmark);
			end
			PH_MAILGT: begin
				if (c != " ") hdr_error(ERR_TAGGER_FIELD, hp_fmark);
				else if (hp_fpos != 0) hdr_error(ERR_NAME, hp_fmark);
				else hp_phase = PH_STAMP1;
			end
			PH_STAMP1: begin
				if (!is_dec(c)) hdr_error(ERR_STAMP, pos);
				else begin
					hp_stamp = c - "0";
					hp_phase = PH_STAMP;
				end
			end
			PH_STAMP: begin
				if (is_dec(c)) begin
					acc = longint'(hp_stamp) * 10 + (c - "0");
					hp_stamp = (acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc[31:0];
				end else if (c == " ") begin
					hp_phase = PH_ZSIGN;
					hp_fmark = pos + 1;
				end else hdr_error(ERR_STAMP_FORM, pos);
			end
			PH_ZSIGN: begin
				if (c == "+" || c == "-") begin
					hp_zneg = (c == "-");
					hp_zacc = 0;
					hp_fpos = 0;
					hp_phase = PH_ZDIG;
				end else hdr_error(ERR_ZONE, hp_fmark);
			end
			PH_ZDIG: begin
				if (!is_dec(c)) hdr_error(ERR_ZONE, hp_fmark);
				else begin
					hp_zacc = hp_zacc * 10 + (c - "0");
					hp_fpos++;
					if (hp_fpos == 4) hp_phase = PH_ZNL;
				end
			end
			PH_ZNL: begin
				if (c != 8'h0a || hp_zacc > ZONE_MAX) hdr_error(ERR_ZONE, hp_fmark);
				else begin
					hp_zone = hp_zneg ? -int'(hp_zacc) : int'(hp_zacc);
					hp_phase = PH_BLANK;
				end
			end
			PH_BLANK: begin
				if (c == 8'h0a) begin
					hp_body = pos + 1;
					hp_phase = PH_BODY;
				end else hdr_error(ERR_GARBAGE, pos);
			end
			default: ;
		endcase
		if (name_char) begin
			if (c == 8'h0a) begin
				if (hp_ncnt >= NAME_LIMIT) hdr_error(ERR_NAMELEN, pos);
				else begin
					hp_phase = PH_TAGGERKW;
					hp_fpos = 0;
				end
			end else if (c <= " ") hdr_error(ERR_NAMECHAR, pos + 1);
			else hp_ncnt = sat_inc(hp_ncnt);
		end
		hp_prev = c;
	endtask

	// byte accepted by the block; the end-of-file byte yields one verdict
	task automatic take_byte(logic [7:0] c, logic last);
		verdict_t v;
		int unsigned sz;
		if (hp_pos < BUFFER_BYTES) begin
			parse_byte(c, hp_pos);
			hp_pos++;
		end
		if (last) begin
			sz = hp_pos;
			parse_byte(8'h00, sz);   // end of buffer reads as a zero byte
			v.status = (sz < MIN_SIZE) ? ERR_SHORT : hp_err;
			v.err_off = (v.status >= ERR_OBJECT) ? cap12(hp_err_off) : 12'd0;
			v.type_len = (hp_tcnt > 31) ? 5'd31 : hp_tcnt[4:0];
			v.name_len = (hp_ncnt > 63) ? 6'd63 : hp_ncnt[5:0];
			v.stamp = hp_stamp;
			v.zone = hp_zone[11:0];
			v.body = (v.status == ERR_NONE) ? cap12(hp_body) : 12'd0;
			verdicts_due.push_back(v);
			parser_clear();
		end
	endtask

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
		fails++;
	endtask

	// ---------------------------------------------------------------
	// File construction
	// ---------------------------------------------------------------
	function automatic logic [7:0] rand_except(logic [7:0] a, logic [7:0] b,
			logic [7:0] c, logic [7:0] d, logic [7:0] e);
		logic [7:0] r;
		do r = $urandom_range(1, 255);
		while (r == a || r == b || r == c || r == d || r == e);
		return r;
	endfunction

	task automatic put_str(string s);
		foreach (s[i]) file_buf.push_back(s[i]);
	endtask

	// well-formed header with random content; the sizes pick the edge cases
	task automatic build_file(int tlen, int nlen, int alen, int mlen, int sdig,
			int zval, bit zneg, int blen);
		string hex_chars;
		int    zdigits[4];
		hex_chars = "0123456789abcdefABCDEF";
		file_buf.delete();
		put_str("object ");
		repeat (40) file_buf.push_back(hex_chars[$urandom_range(0, 21)]);
		put_str("\ntype ");
		repeat (tlen) file_buf.push_back(rand_except(8'h0a, 8'h0a, 8'h0a, 8'h0a, 8'h0a));
		file_buf.push_back(8'h0a);
		mark_tag = file_buf.size();
		put_str("tag ");
		repeat (nlen) file_buf.push_back($urandom_range(8'h21, 8'hff));
		file_buf.push_back(8'h0a);
		mark_tagger = file_buf.size();
		put_str("tagger ");
		repeat (alen) file_buf.push_back(rand_except("<", ">", 8'h0a, 8'h0a, 8'h0a));
		put_str(" <");
		repeat (mlen) file_buf.push_back(rand_except("<", ">", 8'h0a, " ", " "));
		put_str("> ");
		mark_stamp = file_buf.size();
		repeat (sdig) file_buf.push_back($urandom_range("0", "9"));
		file_buf.push_back(" ");
		mark_zone = file_buf.size();
		file_buf.push_back(zneg ? "-" : "+");
		zdigits[0] = zval / 1000 % 10;
		zdigits[1] = zval / 100 % 10;
		zdigits[2] = zval / 10 % 10;
		zdigits[3] = zval % 10;
		foreach (zdigits[i]) file_buf.push_back(8'("0" + zdigits[i]));
		file_buf.push_back(8'h0a);
		mark_blank = file_buf.size();
		file_buf.push_back(8'h0a);
		repeat (blen) file_buf.push_back($urandom_range(0, 255));
	endtask

	task automatic build_random();
		build_file($urandom_range(0, 24), $urandom_range(1, 44), $urandom_range(0, 10),
			$urandom_range(0, 8), $urandom_range(1, 12), $urandom_range(0, 1450),
			$urandom_range(0, 1), $urandom_range(0, 12));
	endtask

	// smallest clean header of exactly the minimum size
	task automatic build_small();
		build_file(0, 1, 1, 0, 1, 0, 0, 3);
	endtask

	task automatic poke(int idx, logic [7:0] val);
		if (idx < file_buf.size()) file_buf[idx] = val;
	endtask

	task automatic send_file(bit drain);
		byte_item_t it;
		if (file_buf.size() == 0) file_buf.push_back($urandom_range(0, 255));
		foreach (file_buf[i]) begin
			it.data = file_buf[i];
			it.last = (i == file_buf.size() - 1);
			it.drain = drain && (i == 0);
			byte_feed.push_back(it);
		end
	endtask

	// random damage: a wrong byte, a cut, or a control byte in the header
	task automatic damage_file();
		int idx;
		idx = $urandom_range(0, file_buf.size() - 1);
		case ($urandom_range(0, 3))
			0: poke(idx, $urandom_range(0, 255));
			1: while (file_buf.size() > idx + 1) void'(file_buf.pop_back());
			2: poke(idx, $urandom_range(0, 2) == 0 ? 8'h00 : 8'h0a);
			default: poke(idx, " ");
		endcase
	endtask

	// ---------------------------------------------------------------
	// Clock, reset, cycle limit
	// ---------------------------------------------------------------
	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// idling is switched off for one long stretch in the middle of the run
	function automatic bit idle_now();
		return !(cycles >= 800 && cycles < 1400) && ($urandom_range(0, 99) < 6);
	endfunction

	// ---------------------------------------------------------------
	// Byte driver: holds an item until taken, predicts on acceptance
	// ---------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		byte_item_t nxt;
		bit         taken;
		if (!arst_n) begin
			in_ch.valid <= 0;
			in_ch.data_byte <= 0;
			in_ch.end_of_file <= 0;
		end else begin
			taken = in_ch.valid && in_ch.ready;
			if (taken) begin
				take_byte(in_ch.data_byte, in_ch.end_of_file);
				bytes_taken <= bytes_taken + 1;
			end
			if (!in_ch.valid || taken) begin
				if (byte_feed.size() != 0 && !idle_now() &&
						!(byte_feed[0].drain && verdicts_due.size() != 0)) begin
					nxt = byte_feed.pop_front();
					in_ch.valid <= 1;
					in_ch.data_byte <= nxt.data;
					in_ch.end_of_file <= nxt.last;
				end else begin
					in_ch.valid <= 0;
				end
			end
		end
	end

	// one long output hold, so the block backs up and stalls its input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 0;
		end else if (!hold_done && bytes_taken >= HOLD_START) begin
			hold_done <= 1;
			hold_left <= HOLD_CYCLES;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// ---------------------------------------------------------------
	// Result monitor
	// ---------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		verdict_t v;
		if (!arst_n) begin
			out_ch.ready <= 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (verdicts_due.size() == 0) begin
					report("result with none pending", 1, 0);
				end else begin
					v = verdicts_due.pop_front();
					if (out_ch.status !== v.status) report("status", out_ch.status, v.status);
					if (out_ch.error_offset !== v.err_off)
						report("error_offset", out_ch.error_offset, v.err_off);
					if (out_ch.type_length !== v.type_len)
						report("type_length", out_ch.type_length, v.type_len);
					if (out_ch.tag_name_length !== v.name_len)
						report("tag_name_length", out_ch.tag_name_length, v.name_len);
					if (out_ch.time_stamp !== v.stamp)
						report("time_stamp", out_ch.time_stamp, v.stamp);
					if (out_ch.zone_offset !== v.zone)
						report("zone_offset", out_ch.zone_offset, v.zone);
					if (out_ch.body_start !== v.body)
						report("body_start", out_ch.body_start, v.body);
				end
			end
			out_ch.ready <= (hold_left == 0) && !idle_now();
		end
	end

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------
	initial begin
		int n_files;
		fails = 0;
		cycles = 0;
		bytes_taken = 0;
		parser_clear();

		// directed: short buffers, one per extreme byte value
		file_buf = '{8'h00}; send_file(0);
		file_buf = '{8'hff}; send_file(0);
		// clean header of exactly the minimum size
		build_file(3, 1, 1, 0, 1, 0, 0, 0); send_file(0);
		// truncated just under 84 bytes: short wins over the header error
		build_file(3, 1, 1, 0, 1, 0, 0, 0);
		while (file_buf.size() > 83) void'(file_buf.pop_back());
		send_file(0);
		// one per header error
		build_small(); poke(0, "O"); send_file(0);
		build_small(); poke(20, "g"); send_file(0);
		build_small(); poke(49, "T"); send_file(0);
		build_file(5, 3, 2, 2, 3, 100, 0, 2); poke(54, 8'h00); send_file(0);
		build_small(); poke(mark_tag + 1, "x"); send_file(0);
		build_file(20, 5, 2, 2, 3, 100, 0, 2); send_file(0);     // type at bound
		build_file(19, 39, 2, 2, 3, 100, 1, 2); send_file(0);    // both just under
		build_file(25, 0, 2, 2, 3, 100, 0, 2); send_file(0);     // empty tag name wins
		build_small(); poke(mark_tag + 5, 8'h1f); send_file(0);
		build_file(3, 40, 2, 2, 3, 100, 0, 2); send_file(0);     // name at bound
		build_small(); poke(mark_tagger + 2, "G"); send_file(0);
		build_small(); poke(mark_tagger + 7, "<"); send_file(0);
		build_file(3, 4, 0, 3, 3, 100, 0, 2); send_file(0);      // empty tagger name
		build_small(); poke(mark_stamp, "x"); send_file(0);
		build_small(); poke(mark_stamp + 1, "/"); send_file(0);
		build_file(3, 4, 3, 3, 12, 1400, 1, 2); send_file(0);    // stamp saturates
		build_file(3, 4, 3, 3, 5, 1401, 0, 2); send_file(0);     // zone over bound
		build_small(); poke(mark_zone, "*"); send_file(0);
		build_small(); poke(mark_blank, "B"); send_file(1);

		// random files, mostly well formed, plus damaged ones and short noise
		n_files = 0;
		while (byte_feed.size() < TARGET_ITEMS || n_files < MIN_FILES) begin
			case ($urandom_range(0, 9))
				0: begin
					file_buf.delete();
					repeat ($urandom_range(1, 20)) file_buf.push_back($urandom_range(0, 255));
				end
				1, 2, 3: begin
					build_random();
					damage_file();
				end
				default: build_random();
			endcase
			send_file(n_files % 12 == 11);
			n_files++;
		end

		while (byte_feed.size() != 0 || in_ch.valid || verdicts_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (fails == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end

endmodule
`default_nettype wire

@@ tag_header_validator.f @@
+incdir+hdl
hdl/thv_pkg.sv
hdl/thv_in_if.sv
hdl/thv_out_if.sv
hdl/thv_core.sv
hdl/tag_header_validator.sv
tb/tag_header_validator_tb.sv
